FILE: rtl/slir_pkg.sv
// shared codes and types for the sorted list insert/remove unit
package slir_pkg;

    localparam int POS_W = 5;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic do_insert;
        logic do_remove;
    } cell_cmd_t;

endpackage

FILE: rtl/slir_cell.sv
// one slot of the sorted list: holds an entry, compares it, shifts with its neighbors
module slir_cell #(
    parameter int IDENT_WIDTH = 16,
    parameter int CW          = 5,
    parameter int INDEX       = 0
) (
    input  logic                   clk,
    input  slir_pkg::cell_cmd_t    cmd,
    input  logic [IDENT_WIDTH-1:0] id,
    input  logic [CW-1:0]          used,
    input  logic                   prev_ge,
    input  logic [IDENT_WIDTH-1:0] prev_entry,
    input  logic [IDENT_WIDTH-1:0] next_entry,
    output logic [IDENT_WIDTH-1:0] entry,
    output logic                   ge,
    output logic                   ins_sel,
    output logic                   rem_sel
);
    import slir_pkg::*;

    logic [IDENT_WIDTH-1:0] entry_reg;
    logic                   occupied;
    logic                   at_end;
    logic                   eq;

    assign occupied = used > CW'(INDEX);
    assign at_end   = used == CW'(INDEX);
    assign ge       = occupied && (entry_reg >= id);
    assign eq       = occupied && (entry_reg == id);

    // first slot not smaller than id, or the first free slot
    assign ins_sel  = !prev_ge && (ge || at_end);
    // first equal slot: everything below it is smaller
    assign rem_sel  = !prev_ge && eq;

    assign entry    = entry_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.do_insert)
        begin
            if (prev_ge)
            begin
                entry_reg <= prev_entry;
            end
            else if (ins_sel)
            begin
                entry_reg <= id;
            end
        end
        else if (cmd.do_remove && ge)
        begin
            entry_reg <= next_entry;
        end
    end

endmodule

FILE: rtl/sorted_list_insert_remove_unit.sv
// top level of the sorted list insert/remove unit
//
// keeps up to CAPACITY identifiers in ascending order in a row of cells, one
// entry per cell. an insert item goes before the first entry not smaller than
// it (so before any equal entries); a remove item deletes the lowest equal
// entry. every cell compares its entry against the item's identifier and
// shifts from its left or right neighbor in the same clock, so one item is
// taken per cycle and its result is registered in the output register in the
// cycle after acceptance. a new item is taken while the result register is
// empty or being drained in that cycle. after reset the list is empty at once;
// no clearing pass is needed since only slots below the count are ever looked at.
module sorted_list_insert_remove_unit #(
    parameter int CAPACITY    = 16,
    parameter int IDENT_WIDTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    input  logic [15:0] ident,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [slir_pkg::POS_W-1:0] position,
    output logic [slir_pkg::POS_W-1:0] entry_count
);
    import slir_pkg::*;

    // count width: must hold CAPACITY itself
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]          used_reg, used_next;
    logic                   out_valid_reg;
    logic [1:0]             status_reg, status_next;
    logic [POS_W-1:0]       position_reg, position_next;
    logic [POS_W-1:0]       count_reg, count_next;

    logic                   accept;
    logic                   full;
    logic                   found;
    logic [IDENT_WIDTH+15:0] id_wide;
    logic [IDENT_WIDTH-1:0] id;
    cell_cmd_t              cmd;

    logic [IDENT_WIDTH-1:0] ent [CAPACITY];
    logic [CAPACITY-1:0]    ge;
    logic [CAPACITY-1:0]    ins_sel;
    logic [CAPACITY-1:0]    rem_sel;

    logic [CW-1:0]          ins_pos;
    logic [CW-1:0]          rem_pos;
    logic [CW-1:0]          res_pos;
    logic [CW+POS_W-1:0]    pos_wide;
    logic [CW+POS_W-1:0]    cnt_wide;

    // only the low IDENT_WIDTH bits of the identifier take part
    assign id_wide = {{IDENT_WIDTH{1'b0}}, ident};
    assign id      = id_wide[IDENT_WIDTH-1:0];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = used_reg == CW'(CAPACITY);
    assign found    = |rem_sel;

    // cells only move when the item really changes the list
    assign cmd.do_insert = accept && (mode == MODE_INSERT) && !full;
    assign cmd.do_remove = accept && (mode == MODE_REMOVE) && found;

    // row of cells, each talking to its two neighbors
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic                   prev_ge_k;
        logic [IDENT_WIDTH-1:0] prev_k;
        logic [IDENT_WIDTH-1:0] next_k;

        if (k == 0)
        begin : g_first
            assign prev_ge_k = 1'b0;
            assign prev_k    = id;
        end
        else
        begin : g_mid
            assign prev_ge_k = ge[k-1];
            assign prev_k    = ent[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign next_k = id;
        end
        else
        begin : g_inner
            assign next_k = ent[k+1];
        end

        slir_cell #(
            .IDENT_WIDTH (IDENT_WIDTH),
            .CW          (CW),
            .INDEX       (k)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .id         (id),
            .used       (used_reg),
            .prev_ge    (prev_ge_k),
            .prev_entry (prev_k),
            .next_entry (next_k),
            .entry      (ent[k]),
            .ge         (ge[k]),
            .ins_sel    (ins_sel[k]),
            .rem_sel    (rem_sel[k])
        );
    end

    // one-hot to index: each select line is set in at most one cell
    always_comb
    begin
        ins_pos = '0;
        rem_pos = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            ins_pos = ins_pos | (ins_sel[k] ? CW'(k) : '0);
            rem_pos = rem_pos | (rem_sel[k] ? CW'(k) : '0);
        end
    end

    always_comb
    begin
        used_next   = used_reg;
        status_next = ST_DONE;
        res_pos     = used_reg;
        if (mode == MODE_INSERT)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                res_pos   = ins_pos;
                used_next = used_reg + CW'(1);
            end
        end
        else
        begin
            if (found)
            begin
                res_pos   = rem_pos;
                used_next = used_reg - CW'(1);
            end
            else
            begin
                status_next = ST_NOT_FOUND;
            end
        end
    end

    // result fields are the low bits of the index and count
    assign pos_wide      = {{POS_W{1'b0}}, res_pos};
    assign cnt_wide      = {{POS_W{1'b0}}, used_next};
    assign position_next = pos_wide[POS_W-1:0];
    assign count_next    = cnt_wide[POS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                used_reg      <= used_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            position_reg <= position_next;
            count_reg    <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign position    = position_reg;
    assign entry_count = count_reg;

endmodule

FILE: rtl/slir_checker.sv
// port-level checks for the sorted list insert/remove unit, bound to the top level
module slir_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       mode,
    input logic [15:0] ident,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [slir_pkg::POS_W-1:0] position,
    input logic [slir_pkg::POS_W-1:0] entry_count
);
    import slir_pkg::*;

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(position) && $stable(entry_count))
        else $error("result changed while stalled");

    // every accepted item yields a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item produced no result");

    // with no result pending the unit must take items
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("not ready with empty result register");

    // a failed item reports the count as its position
    a_fail_position: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL || status == ST_NOT_FOUND)
            |-> position == entry_count)
        else $error("failed item position differs from count");

endmodule

bind sorted_list_insert_remove_unit slir_checker u_slir_checker (.*);

FILE: tb/sv/tb_sorted_list_insert_remove_unit.sv
// testbench for the sorted list insert/remove unit: directed table, then random traffic
`timescale 1ns / 100ps

module tb_sorted_list_insert_remove_unit;
    import slir_pkg::*;

    localparam int CAPACITY   = 16;
    localparam int RAND_ITEMS = 1525;
    localparam int MAX_WAIT   = 17;

    // one result item, as the block reports it
    typedef struct packed {
        logic [1:0]         status;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   entry_count;
    } list_result_t;

    // one row of the directed table; rows with has_want carry a hand-typed result
    typedef struct packed {
        logic               has_want;
        logic               mode;
        logic [15:0]        ident;
        logic [1:0]         status;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   entry_count;
    } plan_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               mode = MODE_INSERT;
    logic [15:0]        ident = 16'h0000;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   entry_count;

    // predicted list contents and the results still owed by the block
    logic [15:0]        shelf [CAPACITY];
    logic [POS_W-1:0]   shelf_used = '0;
    list_result_t       owed_results [$];
    int                 errors = 0;
    int                 in_calm = 0;
    int                 out_calm = 0;

    // directed table: starts from the empty list, walks both extremes of ident,
    // equal entries, a miss on remove, fills the list and pushes past full
    plan_row_t plan [25] = '{
        // remove from the empty list
        '{1'b1, MODE_REMOVE, 16'h0000, ST_NOT_FOUND, 5'd0,  5'd0},
        '{1'b1, MODE_INSERT, 16'hFFFF, ST_DONE,      5'd0,  5'd1},
        '{1'b1, MODE_INSERT, 16'h0000, ST_DONE,      5'd0,  5'd2},
        // an equal ident goes in front of the one already stored
        '{1'b1, MODE_INSERT, 16'h0000, ST_DONE,      5'd0,  5'd3},
        '{1'b1, MODE_INSERT, 16'h8000, ST_DONE,      5'd2,  5'd4},
        '{1'b1, MODE_INSERT, 16'h7FFF, ST_DONE,      5'd2,  5'd5},
        // miss on a non-empty list reports the count as position
        '{1'b1, MODE_REMOVE, 16'h1234, ST_NOT_FOUND, 5'd5,  5'd5},
        // remove takes the lowest of the equal entries
        '{1'b1, MODE_REMOVE, 16'h0000, ST_DONE,      5'd0,  5'd4},
        // fill up to capacity, positions left to the predictor
        '{1'b0, MODE_INSERT, 16'h5555, ST_DONE,      5'd0,  5'd0},
        '{1'b0, MODE_INSERT, 16'hAAAA, ST_DONE,      5'd0,  5'd0},
        '{1'b0, MODE_INSERT, 16'h0001, ST_DONE,      5'd0,  5'd0},
        '{1'b0, MODE_INSERT, 16'hFFFE, ST_DONE,      5'd0,  5'd0},
        '{1'b0, MODE_INSERT, 16'h1234, ST_DONE,      5'd0,  5'd0},
        '{1'b0, MODE_INSERT, 16'h8000, ST_DONE,      5'd0,  5'd0},
        '{1'b0, MODE_INSERT, 16'h00FF, ST_DONE,      5'd0,  5'd0},
        '{1'b0, MODE_INSERT, 16'hFF00, ST_DONE,      5'd0,  5'd0},
        '{1'b0, MODE_INSERT, 16'h7FFF, ST_DONE,      5'd0,  5'd0},
        '{1'b0, MODE_INSERT, 16'h3C3C, ST_DONE,      5'd0,  5'd0},
        '{1'b0, MODE_INSERT, 16'hC3C3, ST_DONE,      5'd0,  5'd0},
        '{1'b0, MODE_INSERT, 16'h0000, ST_DONE,      5'd0,  5'd0},
        // list is full now: the insert bounces and nothing moves
        '{1'b1, MODE_INSERT, 16'h4000, ST_FULL,      5'd16, 5'd16},
        // the single max ident sits in the top slot
        '{1'b1, MODE_REMOVE, 16'hFFFF, ST_DONE,      5'd15, 5'd15},
        '{1'b1, MODE_INSERT, 16'hFFFF, ST_DONE,      5'd15, 5'd16},
        '{1'b1, MODE_REMOVE, 16'h0000, ST_DONE,      5'd0,  5'd15},
        '{1'b1, MODE_REMOVE, 16'h0000, ST_DONE,      5'd0,  5'd14}
    };

    sorted_list_insert_remove_unit #(
        .CAPACITY    (CAPACITY),
        .IDENT_WIDTH (16)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .ident       (ident),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .position    (position),
        .entry_count (entry_count)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // applies one item to the predicted list and returns what the block should say
    function automatic list_result_t shelf_apply(input logic op, input logic [15:0] id);
        list_result_t r;
        int           slot;
        int           k;
        slot = 0;
        if (op == MODE_INSERT)
        begin
            if (shelf_used >= CAPACITY)
            begin
                r = '{ST_FULL, shelf_used, shelf_used};
            end
            else
            begin
                // first stored entry that is not smaller than the new ident
                while (slot < shelf_used && shelf[slot] < id)
                    slot++;
                for (k = shelf_used; k > slot; k--)
                    shelf[k] = shelf[k-1];
                shelf[slot] = id;
                shelf_used = shelf_used + 1'b1;
                r = '{ST_DONE, slot[POS_W-1:0], shelf_used};
            end
        end
        else
        begin
            // lowest-indexed equal entry
            while (slot < shelf_used && shelf[slot] != id)
                slot++;
            if (slot >= shelf_used)
            begin
                r = '{ST_NOT_FOUND, shelf_used, shelf_used};
            end
            else
            begin
                for (k = slot; k + 1 < shelf_used; k++)
                    shelf[k] = shelf[k+1];
                shelf_used = shelf_used - 1'b1;
                r = '{ST_DONE, slot[POS_W-1:0], shelf_used};
            end
        end
        return r;
    endfunction

    // one line per mismatch
    task automatic flag_mismatch(input string what, input int got, input int want);
        errors++;
        $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // offers one item, holding it steady until the block takes it; the item is
    // predicted on the edge where it is accepted
    task automatic offer_item(input logic op, input logic [15:0] id, input logic has_want,
                              input list_result_t want);
        int           gap;
        list_result_t calc;
        if (in_calm > 0)
        begin
            gap = 0;
            in_calm--;
        end
        else if ($urandom_range(0, 29) == 0)
        begin
            gap = 0;
            in_calm = $urandom_range(20, 60);
        end
        else
        begin
            gap = $urandom_range(0, MAX_WAIT);
        end
        // valid is only lowered when there really is a gap before this item
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        ident    <= id;
        do
            @(posedge clk);
        while (!in_ready);
        calc = shelf_apply(op, id);
        owed_results.push_back(has_want ? want : calc);
    endtask

    // result checker: every taken result is held against the oldest one owed
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_results.size() == 0)
            begin
                flag_mismatch("result with nothing owed, status", status, -1);
            end
            else
            begin
                want = owed_results.pop_front();
                if (status !== want.status)
                    flag_mismatch("status", status, want.status);
                if (position !== want.position)
                    flag_mismatch("position", position, want.position);
                if (entry_count !== want.entry_count)
                    flag_mismatch("entry_count", entry_count, want.entry_count);
            end
        end
    end

    // result side: stalls a random number of cycles before each result, with
    // runs of back-to-back draining now and then
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (out_calm > 0)
            begin
                stall = 0;
                out_calm--;
            end
            else if ($urandom_range(0, 29) == 0)
            begin
                stall = 0;
                out_calm = $urandom_range(20, 60);
            end
            else
            begin
                stall = $urandom_range(0, MAX_WAIT);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // run limit, far past the slowest legal run
    initial
    begin
        #20_000_000;
        $display("tb_sorted_list_insert_remove_unit: errors");
        $finish;
    end

    initial
    begin
        int           n;
        int           lean;
        logic         narrow;
        logic         op;
        logic [15:0]  id;
        list_result_t none;

        none = '0;
        lean = 50;
        narrow = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (plan[i])
            offer_item(plan[i].mode, plan[i].ident, plan[i].has_want,
                       '{plan[i].status, plan[i].position, plan[i].entry_count});

        // random part: in blocks of 64 items the insert share swings from mostly
        // removes to nearly all inserts, so the list keeps running empty and full
        for (n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 64 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: lean = 10;
                    1: lean = 50;
                    2: lean = 85;
                    default: lean = 97;
                endcase
                // narrow blocks crowd the list with equal idents at both ends
                narrow = ($urandom_range(0, 2) == 0);
            end
            op = ($urandom_range(0, 99) < lean) ? MODE_INSERT : MODE_REMOVE;
            if (op == MODE_REMOVE && shelf_used != 0 && $urandom_range(0, 99) < 70)
                id = shelf[$urandom_range(0, shelf_used - 1)];
            else if (narrow)
                id = ($urandom_range(0, 1) ? 16'hFFF8 : 16'h0000) | 16'($urandom_range(0, 7));
            else
                id = 16'($urandom);
            offer_item(op, id, 1'b0, none);
        end
        in_valid <= 1'b0;

        // wait out the owed results, then keep watching for stray ones
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        if (errors == 0)
            $display("tb_sorted_list_insert_remove_unit: clean");
        else
            $display("tb_sorted_list_insert_remove_unit: errors");
        $finish;
    end

endmodule
